@@ rtl/core/string_to_integer_parser_unit_defines.svh @@
// Assertion macros shared by the checker of the integer parser.
`ifndef STRING_TO_INTEGER_PARSER_UNIT_DEFINES_SVH
`define STRING_TO_INTEGER_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STIP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stip same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define STIP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stip next-cycle check failed");

`endif

@@ rtl/core/stip_pkg.sv @@
`timescale 1ns / 1ps
package stip_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX       = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_MODE = 4'd1;

   localparam logic [5:0] RADIX_RESET = 6'd10;
   localparam logic [5:0] MAX_RADIX   = 6'd36;
   localparam logic [5:0] DIGIT_NONE  = 6'd36;

   localparam logic [63:0] SIGNED_LIMIT   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] SIGNED_MAX     = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] UNSIGNED_LIMIT = 64'hffff_ffff_ffff_ffff;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_DIGITS = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;
   localparam logic [1:0] STATUS_BAD_BASE  = 2'd3;

   localparam logic [1:0] BASE_KEEP  = 2'd0;
   localparam logic [1:0] BASE_SET8  = 2'd1;
   localparam logic [1:0] BASE_SET10 = 2'd2;
   localparam logic [1:0] BASE_SET16 = 2'd3;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7a;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
      logic [15:0] end_index;
   } rsp_payload_type;

   typedef struct packed {
      logic [5:0] base_cur;
      logic [5:0] digit;
      logic       is_space;
      logic       is_sign;
      logic       is_minus;
      logic       is_zero;
      logic       is_x;
      logic       last;
      logic       rsp_busy;
   } stip_status_type;

   typedef struct packed {
      logic       accept;
      logic       in_ws;
      logic       take;
      logic       set_minus;
      logic [1:0] base_op;
   } stip_cmd_type;

   function automatic logic [5:0] digit_of(input logic [7:0] c);
      logic [5:0] d;
      d = DIGIT_NONE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = 6'(c - CHAR_ZERO);
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         d = 6'(c - CHAR_LO_A) + 6'd10;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         d = 6'(c - CHAR_UP_A) + 6'd10;
      end
      return d;
   endfunction

endpackage

@@ rtl/core/stip_controller.sv @@
`timescale 1ns / 1ps
module stip_controller
   import stip_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  stip_status_type status,
   output stip_cmd_type    cmd
);

   localparam logic [2:0] PH_WS     = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_ZERO   = 3'd2;
   localparam logic [2:0] PH_ZERO_X = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic       accept;
   logic       cur_ok;
   logic       ten_ok;
   logic       hex_ok;
   logic       st_take;
   logic [2:0] st_phase;
   logic [1:0] st_base_op;

   assign req_stall = status.rsp_busy;
   assign accept    = req_valid & ~req_stall;

   assign cur_ok = (status.base_cur >= 6'd2) && (status.base_cur <= MAX_RADIX) &&
                   (status.digit < status.base_cur);
   assign ten_ok = status.digit < 6'd10;
   assign hex_ok = status.digit < 6'd16;

   // Handling of the first character after whitespace and sign.
   always_comb begin
      st_take    = 1'b0;
      st_phase   = PH_DONE;
      st_base_op = BASE_KEEP;
      if (status.base_cur == '0) begin
         if (status.is_zero) begin
            st_base_op = BASE_SET8;
            st_take    = 1'b1;
            st_phase   = PH_ZERO;
         end else begin
            st_base_op = BASE_SET10;
            st_take    = ten_ok;
            st_phase   = ten_ok ? PH_DIGITS : PH_DONE;
         end
      end else if (status.base_cur == 6'd16 && status.is_zero) begin
         st_take  = 1'b1;
         st_phase = PH_ZERO;
      end else begin
         st_take  = cur_ok;
         st_phase = cur_ok ? PH_DIGITS : PH_DONE;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      cmd.accept    = accept;
      cmd.in_ws     = (phase_ff == PH_WS);
      cmd.take      = 1'b0;
      cmd.set_minus = 1'b0;
      cmd.base_op   = BASE_KEEP;
      if (accept) begin
         unique case (phase_ff)
            PH_WS: begin
               if (status.is_space) begin
                  phase_in = PH_WS;
               end else if (status.is_sign) begin
                  cmd.set_minus = status.is_minus;
                  phase_in      = PH_START;
               end else begin
                  cmd.take    = st_take;
                  cmd.base_op = st_base_op;
                  phase_in    = st_phase;
               end
            end
            PH_START: begin
               cmd.take    = st_take;
               cmd.base_op = st_base_op;
               phase_in    = st_phase;
            end
            PH_ZERO: begin
               if (status.is_x) begin
                  phase_in = PH_ZERO_X;
               end else begin
                  cmd.take = cur_ok;
                  phase_in = cur_ok ? PH_DIGITS : PH_DONE;
               end
            end
            PH_ZERO_X: begin
               if (hex_ok) begin
                  cmd.base_op = BASE_SET16;
                  cmd.take    = 1'b1;
                  phase_in    = PH_DIGITS;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_DIGITS: begin
               cmd.take = cur_ok;
               phase_in = cur_ok ? PH_DIGITS : PH_DONE;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (status.last) begin
            phase_in = PH_WS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WS;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

@@ rtl/core/stip_datapath.sv @@
`timescale 1ns / 1ps
module stip_datapath
   import stip_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  req_payload_type        req_payload,
   input  stip_cmd_type           cmd,
   output stip_status_type        status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload
);

   logic [5:0]          radix_ff;
   logic [5:0]          radix_in;
   logic                signed_mode_ff;
   logic                signed_mode_in;
   logic [63:0]         accum_ff;
   logic [63:0]         accum_in;
   logic                minus_ff;
   logic                minus_in;
   logic                overflow_ff;
   logic                overflow_in;
   logic                have_digit_ff;
   logic                have_digit_in;
   logic [5:0]          base_ff;
   logic [5:0]          base_in;
   logic [POS_BITS-1:0] position_ff;
   logic [POS_BITS-1:0] position_in;
   logic [POS_BITS-1:0] stop_ff;
   logic [POS_BITS-1:0] stop_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_payload_type     rsp_data_ff;
   rsp_payload_type     rsp_data_in;

   logic [5:0]          base_cur;
   logic [5:0]          base_new;
   logic [5:0]          digit;
   logic [69:0]         product;
   logic [70:0]         sum;
   logic [63:0]         limit;
   logic                over_now;
   logic [63:0]         step_accum;
   logic                step_overflow;
   logic                step_have;
   logic                step_minus;
   logic [POS_BITS-1:0] step_stop;
   logic [63:0]         mag;
   logic [31:0]         stop_wide;
   rsp_payload_type     result;

   assign base_cur = (cmd.in_ws && position_ff == '0) ? radix_ff : base_ff;
   assign digit    = digit_of(req_payload.ch);

   always_comb begin
      status.base_cur = base_cur;
      status.digit    = digit;
      status.is_space = (req_payload.ch == CHAR_SPACE) ||
                        (req_payload.ch >= CHAR_TAB && req_payload.ch <= CHAR_CR);
      status.is_sign  = (req_payload.ch == CHAR_PLUS) || (req_payload.ch == CHAR_MINUS);
      status.is_minus = (req_payload.ch == CHAR_MINUS);
      status.is_zero  = (req_payload.ch == CHAR_ZERO);
      status.is_x     = (req_payload.ch == CHAR_LO_X) || (req_payload.ch == CHAR_UP_X);
      status.last     = req_payload.last;
      status.rsp_busy = rsp_valid_ff & rsp_stall;
   end

   always_comb begin
      unique case (cmd.base_op)
         BASE_KEEP:  base_new = base_cur;
         BASE_SET8:  base_new = 6'd8;
         BASE_SET10: base_new = 6'd10;
         BASE_SET16: base_new = 6'd16;
         default:    base_new = base_cur;
      endcase
   end

   // The digit fits when accum * base + digit stays at or below the limit.
   assign product  = 70'(accum_ff) * 70'(base_new);
   assign sum      = 71'(product) + 71'(digit);
   assign limit    = signed_mode_ff ? SIGNED_LIMIT : UNSIGNED_LIMIT;
   assign over_now = sum > 71'(limit);

   always_comb begin
      step_accum    = accum_ff;
      step_overflow = overflow_ff;
      step_have     = have_digit_ff;
      step_stop     = stop_ff;
      step_minus    = minus_ff | cmd.set_minus;
      if (cmd.take) begin
         if (over_now) begin
            step_overflow = 1'b1;
         end else if (!overflow_ff) begin
            step_accum = sum[63:0];
         end
         step_have = 1'b1;
         step_stop = position_ff + POS_BITS'(1);
      end
   end

   assign stop_wide = 32'(step_stop);

   always_comb begin
      result.value     = '0;
      result.status    = STATUS_OK;
      result.end_index = '0;
      mag              = '0;
      if (base_new == 6'd1 || base_new > MAX_RADIX) begin
         result.status = STATUS_BAD_BASE;
      end else if (!step_have) begin
         result.status = STATUS_NO_DIGITS;
      end else begin
         result.status    = step_overflow ? STATUS_RANGE : STATUS_OK;
         result.end_index = stop_wide[15:0];
         if (signed_mode_ff) begin
            mag = step_overflow ? SIGNED_LIMIT : step_accum;
            if (!step_minus) begin
               if (mag > SIGNED_MAX) begin
                  result.value  = SIGNED_MAX;
                  result.status = STATUS_RANGE;
               end else begin
                  result.value = mag;
               end
            end else begin
               result.value = (~mag) + 64'd1;
            end
         end else begin
            mag          = step_overflow ? UNSIGNED_LIMIT : step_accum;
            result.value = step_minus ? ((~mag) + 64'd1) : mag;
         end
      end
   end

   always_comb begin
      radix_in       = radix_ff;
      signed_mode_in = signed_mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIX:       radix_in       = csr_wdata[5:0];
            CSR_SIGNED_MODE: signed_mode_in = csr_wdata[0];
            default: begin
               radix_in       = radix_ff;
               signed_mode_in = signed_mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      accum_in      = accum_ff;
      minus_in      = minus_ff;
      overflow_in   = overflow_ff;
      have_digit_in = have_digit_ff;
      base_in       = base_ff;
      position_in   = position_ff;
      stop_in       = stop_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      if (cmd.accept) begin
         base_in = base_new;
         if (req_payload.last) begin
            accum_in      = '0;
            minus_in      = 1'b0;
            overflow_in   = 1'b0;
            have_digit_in = 1'b0;
            position_in   = '0;
            stop_in       = '0;
            rsp_data_in   = result;
            rsp_valid_in  = 1'b1;
         end else begin
            accum_in      = step_accum;
            minus_in      = step_minus;
            overflow_in   = step_overflow;
            have_digit_in = step_have;
            position_in   = position_ff + POS_BITS'(1);
            stop_in       = step_stop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= RADIX_RESET;
         signed_mode_ff <= 1'b1;
         accum_ff       <= '0;
         minus_ff       <= 1'b0;
         overflow_ff    <= 1'b0;
         have_digit_ff  <= 1'b0;
         base_ff        <= RADIX_RESET;
         position_ff    <= '0;
         stop_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         radix_ff       <= radix_in;
         signed_mode_ff <= signed_mode_in;
         accum_ff       <= accum_in;
         minus_ff       <= minus_in;
         overflow_ff    <= overflow_in;
         have_digit_ff  <= have_digit_in;
         base_ff        <= base_in;
         position_ff    <= position_in;
         stop_ff        <= stop_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

@@ rtl/core/string_to_integer_parser_unit.sv @@
`timescale 1ns / 1ps
// Latency: the result of a string is valid in the cycle after the transfer of its last character.
// Throughput: one character per cycle; the digit multiply-add and limit compare are combinational.
// The input stalls only while a finished result is held by a stalled output.
// Reset is synchronous and active high: radix returns to 10, signed mode to 1, the parse
// state to the whitespace phase, and no result is pending.
module string_to_integer_parser_unit
   import stip_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   stip_status_type status;
   stip_cmd_type    cmd;

   assign csr_ready = 1'b1;

   stip_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stip_datapath #(
      .POS_BITS (POS_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/core/stip_checker.sv @@
`timescale 1ns / 1ps
`include "string_to_integer_parser_unit_defines.svh"
module stip_checker
   import stip_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   `STIP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   `STIP_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   `STIP_ASSERT_NOW(a_rsp_source, clock, reset, rsp_valid && !($past(rsp_valid) && $past(rsp_stall)), $past(req_valid) && !$past(req_stall) && $past(req_payload.last))

   `STIP_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind string_to_integer_parser_unit stip_checker u_stip_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

@@ tb/sv/tb_string_to_integer_parser_unit.sv @@
`timescale 1ns / 1ps
module tb_string_to_integer_parser_unit;
   import stip_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   typedef enum logic [2:0] {
      SCAN_SPACE,
      SCAN_SIGN,
      SCAN_ZERO,
      SCAN_ZERO_X,
      SCAN_DIGITS,
      SCAN_DONE
   } scan_phase_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [5:0]      cfg_radix;
   logic            cfg_signed;
   scan_phase_type  pr_phase;
   logic [63:0]     pr_accum;
   logic            pr_minus;
   logic            pr_ovf;
   logic            pr_have;
   logic [5:0]      pr_base;
   logic [15:0]     pr_pos;
   logic [15:0]     pr_stop;
   rsp_payload_type number_q[$];

   int send_idle_pct;
   int rsp_idle_pct;
   int rsp_hold_left;
   int mismatch_count;
   int quiet_cycles;

   string_to_integer_parser_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [5:0] char_digit(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         return 6'(c - CHAR_ZERO);
      end
      if (folded >= CHAR_LO_A && folded <= CHAR_LO_Z) begin
         return 6'(folded - CHAR_LO_A + 8'd10);
      end
      return DIGIT_NONE;
   endfunction

   task automatic clear_number();
      pr_phase = SCAN_SPACE;
      pr_accum = 64'd0;
      pr_minus = 1'b0;
      pr_ovf   = 1'b0;
      pr_have  = 1'b0;
      pr_pos   = 16'd0;
      pr_stop  = 16'd0;
   endtask

   task automatic add_digit(input logic [5:0] d);
      logic [63:0] lim;
      lim = cfg_signed ? SIGNED_LIMIT : UNSIGNED_LIMIT;
      if (pr_accum > (lim - 64'(d)) / 64'(pr_base)) begin
         pr_ovf = 1'b1;
      end else if (!pr_ovf) begin
         pr_accum = pr_accum * 64'(pr_base) + 64'(d);
      end
      pr_have = 1'b1;
      pr_stop = pr_pos + 16'd1;
   endtask

   task automatic scan_digit(input logic [7:0] c);
      logic [5:0] d;
      d = char_digit(c);
      if (pr_base < 6'd2 || pr_base > MAX_RADIX || d >= pr_base) begin
         pr_phase = SCAN_DONE;
      end else begin
         add_digit(d);
      end
   endtask

   task automatic scan_first(input logic [7:0] c);
      if (pr_base == 6'd0 && c != CHAR_ZERO) pr_base = 6'd10;
      if (c == CHAR_ZERO && (pr_base == 6'd0 || pr_base == 6'd16)) begin
         if (pr_base == 6'd0) pr_base = 6'd8;
         add_digit(6'd0);
         pr_phase = SCAN_ZERO;
      end else begin
         pr_phase = SCAN_DIGITS;
         scan_digit(c);
      end
   endtask

   task automatic parse_char(input req_payload_type it);
      logic [7:0]      c;
      logic [63:0]     mag;
      rsp_payload_type r;
      c = it.ch;
      if (pr_phase == SCAN_SPACE && pr_pos == 16'd0) pr_base = cfg_radix;
      case (pr_phase)
         SCAN_SPACE: begin
            if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
               if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                  if (c == CHAR_MINUS) pr_minus = 1'b1;
                  pr_phase = SCAN_SIGN;
               end else begin
                  scan_first(c);
               end
            end
         end
         SCAN_SIGN: scan_first(c);
         SCAN_ZERO: begin
            if (c == CHAR_LO_X || c == CHAR_UP_X) begin
               pr_phase = SCAN_ZERO_X;
            end else begin
               pr_phase = SCAN_DIGITS;
               scan_digit(c);
            end
         end
         SCAN_ZERO_X: begin
            if (char_digit(c) < 6'd16) begin
               pr_base = 6'd16;
               pr_phase = SCAN_DIGITS;
               add_digit(char_digit(c));
            end else begin
               pr_phase = SCAN_DONE;
            end
         end
         SCAN_DIGITS: scan_digit(c);
         default: ;
      endcase
      pr_pos = pr_pos + 16'd1;
      if (it.last) begin
         r.value = 64'd0;
         r.status = STATUS_NO_DIGITS;
         r.end_index = 16'd0;
         if (pr_base == 6'd1 || pr_base > MAX_RADIX) begin
            r.status = STATUS_BAD_BASE;
         end else if (pr_have) begin
            r.status = pr_ovf ? STATUS_RANGE : STATUS_OK;
            r.end_index = pr_stop;
            if (cfg_signed) begin
               mag = pr_ovf ? SIGNED_LIMIT : pr_accum;
            end else begin
               mag = pr_ovf ? UNSIGNED_LIMIT : pr_accum;
            end
            if (pr_minus) begin
               r.value = 64'd0 - mag;
            end else if (cfg_signed && mag > SIGNED_MAX) begin
               r.value = SIGNED_MAX;
               r.status = STATUS_RANGE;
            end else begin
               r.value = mag;
            end
         end
         number_q.push_back(r);
         clear_number();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch in %s: got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_char(input logic [7:0] c, input logic fin);
      req_payload_type it;
      it.ch = c;
      it.last = fin;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_char(it);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (number_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_RADIX) cfg_radix = data[5:0];
      else if (idx == CSR_SIGNED_MODE) cfg_signed = data[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // The spare data bits are randomized since the block must ignore them.
   task automatic configure(input logic [5:0] radix, input logic sign_mode);
      settle();
      write_csr(CSR_RADIX, {2'($urandom_range(3)), radix});
      write_csr(CSR_SIGNED_MODE, {7'($urandom), sign_mode});
   endtask

   function automatic logic [7:0] digit_char(input int d);
      if (d < 10) return CHAR_ZERO + 8'(d);
      return ($urandom_range(1) ? CHAR_LO_A : CHAR_UP_A) + 8'(d - 10);
   endfunction

   function automatic logic [7:0] blank_char();
      if ($urandom_range(5) == 0) return CHAR_SPACE;
      return CHAR_TAB + 8'($urandom_range(4));
   endfunction

   function automatic logic [5:0] random_radix();
      case ($urandom_range(9))
         0: return 6'd0;
         1: return 6'd2;
         2: return 6'd8;
         3: return 6'd10;
         4: return 6'd16;
         5: return MAX_RADIX;
         6: return 6'd1;
         7: return 6'($urandom_range(37, 63));
         default: return 6'($urandom_range(2, 36));
      endcase
   endfunction

   task automatic send_random_number(output int n_sent);
      logic [7:0] text[$];
      int         base;
      int         len;
      logic       full;
      text = {};
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(2)) text.push_back(blank_char());
         case ($urandom_range(3))
            0: text.push_back(CHAR_PLUS);
            1: text.push_back(CHAR_MINUS);
            default: ;
         endcase
         base = (cfg_radix >= 6'd2 && cfg_radix <= MAX_RADIX) ? int'(cfg_radix) : 10;
         if ((cfg_radix == 6'd0 || cfg_radix == 6'd16) && $urandom_range(2) == 0) begin
            text.push_back(CHAR_ZERO);
            text.push_back($urandom_range(1) ? CHAR_LO_X : CHAR_UP_X);
            base = 16;
         end else if (cfg_radix == 6'd0 && $urandom_range(3) == 0) begin
            text.push_back(CHAR_ZERO);
            base = 8;
         end
         len = ($urandom_range(3) == 0) ? $urandom_range(12, 70) : $urandom_range(6);
         full = ($urandom_range(7) == 0);
         repeat (len) text.push_back(digit_char(full ? base - 1 : $urandom_range(base - 1)));
         if ($urandom_range(3) == 0) text.push_back(8'($urandom_range(255)));
      end
      if (text.size() == 0) text.push_back(8'($urandom_range(255)));
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
      n_sent = text.size();
   endtask

   task automatic test_decimal_limits();
      send_text(" \t+42");
      send_text("-0");
      send_text("9223372036854775807");
      send_text("-9223372036854775808");
      send_text("9223372036854775808");
      send_text("12ab");
   endtask

   task automatic test_signed_overflow();
      send_text("99999999999999999999999");
      send_text("-99999999999999999999999");
   endtask

   task automatic test_unsigned_rules();
      configure(6'd10, 1'b0);
      send_text("18446744073709551615");
      send_text("18446744073709551616");
      send_text("-18446744073709551616");
      send_text("-5");
      send_text("-9223372036854775808");
   endtask

   task automatic test_auto_base();
      configure(6'd0, 1'b1);
      send_text("0x1F");
      send_text("-0X7fffffffffffffff");
      send_text("0x");
      send_text("0xg");
      send_text("017");
      send_text("08");
      send_text("z");
      send_text("0");
   endtask

   task automatic test_hex_radix();
      configure(6'd16, 1'b0);
      send_text("0xffffffffffffffff");
      send_text("0x");
      send_text("ff");
      send_text("0xz");
      send_text("0X1g");
   endtask

   task automatic test_base_extremes();
      configure(6'd2, 1'b1);
      send_text("1011");
      configure(MAX_RADIX, 1'b1);
      send_text("zZ");
      configure(6'd1, 1'b1);
      send_text("1");
      configure(6'd37, 1'b1);
      send_text("5");
      configure(6'd63, 1'b0);
      send_text("5");
   endtask

   task automatic test_blanks_and_junk();
      configure(6'd10, 1'b1);
      send_text("\011\012\013\014\015 7");
      send_text("   ");
      send_text("+-5");
      send_text("- 5");
      send_text("5x99");
      send_char(CHAR_ZERO + 8'd1, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(CHAR_ZERO + 8'd2, 1'b1);
      send_char(8'hff, 1'b0);
      send_char(8'h80, 1'b1);
   endtask

   task automatic test_unused_registers();
      settle();
      for (int idx = CSR_SIGNED_MODE + 1; idx < 2 ** CSR_INDEX_W; idx++) begin
         write_csr(CSR_INDEX_W'(idx), CSR_DATA_W'($urandom));
      end
      send_text("77");
   endtask

   task automatic test_output_backpressure();
      configure(6'd10, 1'b1);
      send_idle_pct = 0;
      rsp_hold_left = 150;
      repeat (10) send_text("-31");
      settle();
      send_idle_pct = 18;
   endtask

   task automatic test_random_strings();
      int sent;
      int n;
      for (int part = 0; part < 3; part++) begin
         send_idle_pct = (part == 0) ? 18 : (part == 1) ? 52 : 0;
         rsp_idle_pct = (part == 0) ? 52 : (part == 1) ? 18 : 0;
         sent = 0;
         while (sent < 400) begin
            configure(random_radix(), 1'($urandom_range(1)));
            repeat (8) begin
               send_random_number(n);
               sent += n;
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_numbers
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (number_q.size() == 0) begin
            report_mismatch("unexpected result value", rsp_payload.value, 64'd0);
         end else begin
            want = number_q.pop_front();
            if (rsp_payload.value !== want.value) begin
               report_mismatch("value", rsp_payload.value, want.value);
            end
            if (rsp_payload.status !== want.status) begin
               report_mismatch("status", 64'(rsp_payload.status), 64'(want.status));
            end
            if (rsp_payload.end_index !== want.end_index) begin
               report_mismatch("end_index", 64'(rsp_payload.end_index), 64'(want.end_index));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 18;
      rsp_idle_pct = 52;
      rsp_hold_left = 0;
      mismatch_count = 0;
      quiet_cycles = 0;
      cfg_radix = RADIX_RESET;
      cfg_signed = 1'b1;
      pr_base = RADIX_RESET;
      clear_number();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_decimal_limits();
      test_signed_overflow();
      test_unsigned_rules();
      test_auto_base();
      test_hex_radix();
      test_base_extremes();
      test_blanks_and_junk();
      test_unused_registers();
      test_output_backpressure();
      test_random_strings();

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/stip_pkg.sv
rtl/core/stip_controller.sv
rtl/core/stip_datapath.sv
rtl/core/string_to_integer_parser_unit.sv
rtl/core/stip_checker.sv
tb/sv/tb_string_to_integer_parser_unit.sv
